### rtl/core/arp_responder_with_ping_detect_assert.svh
// ----------------------------------------------------------------------------
// ARP responder assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ARP_RESPONDER_WITH_PING_DETECT_ASSERT_SVH
`define ARP_RESPONDER_WITH_PING_DETECT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ARPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arpr: same-cycle check failed");

// next-cycle implication, disabled during reset
`define ARPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arpr: next-cycle check failed");

`endif

### rtl/core/arpr_pkg.sv
// ----------------------------------------------------------------------------
// ARP responder package
// Payload types, frame class codes, header offsets and reply layout helpers.
// ----------------------------------------------------------------------------
package arpr_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_last;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [2:0] frame_class;
        logic       run_end;
    } t_tx_item;

    typedef enum logic [2:0] {
        CLS_OTHER      = 3'd0,
        CLS_ARP_US     = 3'd1,
        CLS_ARP_OTHER  = 3'd2,
        CLS_PING_US    = 3'd3,
        CLS_PING_OTHER = 3'd4
    } t_frame_class;

    // job handed from the classifier to the reply sequencer
    typedef struct packed {
        t_frame_class cls;
        logic         bank;
    } t_job;

    // reply sequencer releasing a header bank
    typedef struct packed {
        logic done;
        logic bank;
    } t_back_status;

    typedef enum logic {F_RX, F_EVAL} t_front_state;
    typedef enum logic {B_IDLE, B_RUN} t_back_state;
    typedef enum logic [1:0] {SRC_HDR, SRC_MAC, SRC_OPER_HI, SRC_OPER_LO} t_reply_src;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 8'd1;

    localparam int REPLY_LEN = 42;
    localparam int RIDX_W    = 6;
    localparam int ARP_NEED  = 42;
    localparam int PING_NEED = 35;

    // header offsets
    localparam int POS_ETYPE_HI  = 12;
    localparam int POS_ETYPE_LO  = 13;
    localparam int POS_OPER_HI   = 20;
    localparam int POS_OPER_LO   = 21;
    localparam int POS_IP_PROTO  = 23;
    localparam int POS_PING_DST  = 30;
    localparam int POS_ICMP_TYPE = 34;
    localparam int POS_ARP_TPA   = 38;

    localparam logic [7:0] ETYPE_HI      = 8'h08;
    localparam logic [7:0] ETYPE_ARP_LO  = 8'h06;
    localparam logic [7:0] ETYPE_IP_LO   = 8'h00;
    localparam logic [7:0] OPER_HI       = 8'h00;
    localparam logic [7:0] OPER_REQ_LO   = 8'h01;
    localparam logic [7:0] OPER_REPLY_LO = 8'h02;
    localparam logic [7:0] PROTO_ICMP    = 8'h01;
    localparam logic [7:0] ICMP_ECHO_REQ = 8'h08;

    function automatic t_reply_src reply_src(input logic [RIDX_W-1:0] k);
        t_reply_src src;
        if ((k >= RIDX_W'(6) && k < RIDX_W'(12)) || (k >= RIDX_W'(22) && k < RIDX_W'(28))) begin
            src = SRC_MAC;
        end else if (k == RIDX_W'(POS_OPER_HI)) begin
            src = SRC_OPER_HI;
        end else if (k == RIDX_W'(POS_OPER_LO)) begin
            src = SRC_OPER_LO;
        end else begin
            src = SRC_HDR;
        end
        return src;
    endfunction

    // header offset feeding reply byte k (only meaningful for SRC_HDR bytes)
    function automatic logic [RIDX_W-1:0] reply_hdr_idx(input logic [RIDX_W-1:0] k);
        logic [RIDX_W-1:0] idx;
        if (k < RIDX_W'(6)) begin
            idx = k + RIDX_W'(6);
        end else if (k < RIDX_W'(28)) begin
            idx = k;
        end else if (k < RIDX_W'(32)) begin
            idx = k + RIDX_W'(10);
        end else begin
            idx = k - RIDX_W'(10);
        end
        return idx;
    endfunction

    function automatic logic [7:0] mac_octet(input logic [47:0] mac, input logic [RIDX_W-1:0] k);
        logic [2:0] j;
        logic [7:0] b;
        j = (k < RIDX_W'(12)) ? 3'(k - RIDX_W'(6)) : 3'(k - RIDX_W'(22));
        case (j)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### rtl/core/arpr_fifo.sv
// ----------------------------------------------------------------------------
// ARP responder job queue
// Two-entry queue of classified frames between classifier and sequencer.
// ----------------------------------------------------------------------------
module arpr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  arpr_pkg::t_job  i_data,
    output logic            o_full,
    output logic            o_valid,
    output arpr_pkg::t_job  o_data,
    input  logic            i_pop
);

    arpr_pkg::t_job r_entry [2];
    logic [1:0]     r_count;
    logic [1:0]     n_count;
    logic           r_wr_ptr;
    logic           r_rd_ptr;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/arpr_front.sv
// ----------------------------------------------------------------------------
// ARP responder receive front end
// Takes frame bytes, fills the header buffer, captures the fields that
// decide the class and hands one job per frame to the queue.
// ----------------------------------------------------------------------------
module arpr_front #(
    parameter int  HEADER_BYTES    = 42,
    parameter int  MAX_FRAME_BYTES = 1520,
    localparam int HW              = $clog2(HEADER_BYTES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rx_valid,
    output logic                     o_rx_ready,
    input  arpr_pkg::t_rx_item       i_rx,
    input  logic [31:0]              i_own_ip,
    output logic                     o_wr_en,
    output logic                     o_wr_bank,
    output logic [HW-1:0]            o_wr_idx,
    output logic [7:0]               o_wr_data,
    output logic                     o_push,
    output arpr_pkg::t_job           o_job,
    input  logic                     i_fifo_full,
    input  arpr_pkg::t_back_status   i_status
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    arpr_pkg::t_front_state r_state, n_state;
    logic [PW-1:0]          r_pos, n_pos;
    logic                   r_bank, n_bank;
    logic [1:0]             r_busy, n_busy;

    logic [7:0]  r_b12, r_b13, r_b20, r_b21, r_b23, r_b34;
    logic [31:0] r_ip30, r_ip38;
    logic        r_arp_len, r_ping_len;

    logic                   w_accept;
    logic [PW-1:0]          w_pos_inc;
    logic                   w_is_arp;
    logic                   w_is_ping;
    arpr_pkg::t_frame_class w_cls;

    // a bank still owed to a pending reply is not overwritten
    assign o_rx_ready = (r_state == arpr_pkg::F_RX) && !r_busy[r_bank];
    assign w_accept   = i_rx_valid && o_rx_ready;
    assign w_pos_inc  = (r_pos < PW'(MAX_FRAME_BYTES)) ? r_pos + PW'(1) : r_pos;

    assign o_wr_en   = w_accept && (r_pos < PW'(HEADER_BYTES));
    assign o_wr_bank = r_bank;
    assign o_wr_idx  = r_pos[HW-1:0];
    assign o_wr_data = i_rx.rx_byte;

    assign w_is_arp  = r_arp_len && (r_b12 == arpr_pkg::ETYPE_HI)
                     && (r_b13 == arpr_pkg::ETYPE_ARP_LO) && (r_b20 == arpr_pkg::OPER_HI)
                     && (r_b21 == arpr_pkg::OPER_REQ_LO);
    assign w_is_ping = r_ping_len && (r_b12 == arpr_pkg::ETYPE_HI)
                     && (r_b13 == arpr_pkg::ETYPE_IP_LO) && (r_b23 == arpr_pkg::PROTO_ICMP)
                     && (r_b34 == arpr_pkg::ICMP_ECHO_REQ);

    always_comb begin
        if (w_is_arp) begin
            w_cls = (r_ip38 == i_own_ip) ? arpr_pkg::CLS_ARP_US : arpr_pkg::CLS_ARP_OTHER;
        end else if (w_is_ping) begin
            w_cls = (r_ip30 == i_own_ip) ? arpr_pkg::CLS_PING_US : arpr_pkg::CLS_PING_OTHER;
        end else begin
            w_cls = arpr_pkg::CLS_OTHER;
        end
    end

    assign o_job = '{cls: w_cls, bank: r_bank};

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_bank  = r_bank;
        n_busy  = r_busy;
        o_push  = 1'b0;
        if (i_status.done) begin
            n_busy[i_status.bank] = 1'b0;
        end
        case (r_state)
            arpr_pkg::F_RX: begin
                if (w_accept) begin
                    if (i_rx.rx_last) begin
                        n_pos   = '0;
                        n_state = arpr_pkg::F_EVAL;
                    end else begin
                        n_pos = w_pos_inc;
                    end
                end
            end
            arpr_pkg::F_EVAL: begin
                if (!i_fifo_full) begin
                    o_push  = 1'b1;
                    n_state = arpr_pkg::F_RX;
                    if (w_cls == arpr_pkg::CLS_ARP_US) begin
                        n_busy[r_bank] = 1'b1;
                        n_bank         = !r_bank;
                    end
                end
            end
            default: begin
                n_state = arpr_pkg::F_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arpr_pkg::F_RX;
            r_pos   <= '0;
            r_bank  <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end

    // field capture; a length check guards against stale bytes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (r_pos == PW'(arpr_pkg::POS_ETYPE_HI))  r_b12 <= i_rx.rx_byte;
            if (r_pos == PW'(arpr_pkg::POS_ETYPE_LO))  r_b13 <= i_rx.rx_byte;
            if (r_pos == PW'(arpr_pkg::POS_OPER_HI))   r_b20 <= i_rx.rx_byte;
            if (r_pos == PW'(arpr_pkg::POS_OPER_LO))   r_b21 <= i_rx.rx_byte;
            if (r_pos == PW'(arpr_pkg::POS_IP_PROTO))  r_b23 <= i_rx.rx_byte;
            if (r_pos == PW'(arpr_pkg::POS_ICMP_TYPE)) r_b34 <= i_rx.rx_byte;
            if (r_pos >= PW'(arpr_pkg::POS_PING_DST)
                && r_pos < PW'(arpr_pkg::POS_PING_DST + 4)) begin
                r_ip30 <= {r_ip30[23:0], i_rx.rx_byte};
            end
            if (r_pos >= PW'(arpr_pkg::POS_ARP_TPA)
                && r_pos < PW'(arpr_pkg::POS_ARP_TPA + 4)) begin
                r_ip38 <= {r_ip38[23:0], i_rx.rx_byte};
            end
            if (i_rx.rx_last) begin
                r_arp_len  <= (w_pos_inc >= PW'(arpr_pkg::ARP_NEED));
                r_ping_len <= (w_pos_inc >= PW'(arpr_pkg::PING_NEED));
            end
        end
    end

endmodule

### rtl/core/arpr_back.sv
// ----------------------------------------------------------------------------
// ARP responder reply sequencer
// Holds the two-bank header buffer, drains the job queue and emits a single
// status transaction or the 42-byte ARP reply at one byte per cycle if ready.
// ----------------------------------------------------------------------------
module arpr_back #(
    parameter int  HEADER_BYTES = 42,
    localparam int HW           = $clog2(HEADER_BYTES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic                     i_wr_bank,
    input  logic [HW-1:0]            i_wr_idx,
    input  logic [7:0]               i_wr_data,
    input  logic                     i_job_valid,
    input  arpr_pkg::t_job           i_job,
    output logic                     o_job_pop,
    input  logic [47:0]              i_own_mac,
    output arpr_pkg::t_back_status   o_status,
    output logic                     o_tx_valid,
    input  logic                     i_tx_ready,
    output arpr_pkg::t_tx_item       o_tx
);

    localparam int DEPTH = 2 * HEADER_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = arpr_pkg::RIDX_W;

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd_data;

    arpr_pkg::t_back_state r_state, n_state;
    logic [RW-1:0]         r_k, n_k;
    logic                  r_bank, n_bank;
    logic                  r_tx_valid, n_tx_valid;
    arpr_pkg::t_tx_item    r_tx, n_tx;

    logic          w_out_free;
    logic          w_rd_en;
    logic          w_rd_bank;
    logic [RW-1:0] w_rd_k;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_byte;

    assign w_wr_addr = AW'(i_wr_idx) + (i_wr_bank ? AW'(HEADER_BYTES) : AW'(0));
    assign w_rd_addr = AW'(arpr_pkg::reply_hdr_idx(w_rd_k))
                     + (w_rd_bank ? AW'(HEADER_BYTES) : AW'(0));

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[w_wr_addr] <= i_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_comb begin
        case (arpr_pkg::reply_src(r_k))
            arpr_pkg::SRC_HDR:     w_byte = r_rd_data;
            arpr_pkg::SRC_MAC:     w_byte = arpr_pkg::mac_octet(i_own_mac, r_k);
            arpr_pkg::SRC_OPER_HI: w_byte = arpr_pkg::OPER_HI;
            arpr_pkg::SRC_OPER_LO: w_byte = arpr_pkg::OPER_REPLY_LO;
            default:               w_byte = 8'h00;
        endcase
    end

    assign w_out_free = !r_tx_valid || i_tx_ready;

    // read for byte k+1 goes out while byte k is loaded into the output register
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_bank     = r_bank;
        n_tx_valid = r_tx_valid && !i_tx_ready;
        n_tx       = r_tx;
        o_job_pop  = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_bank  = r_bank;
        w_rd_k     = r_k;
        o_status   = '0;
        case (r_state)
            arpr_pkg::B_IDLE: begin
                if (i_job_valid && w_out_free) begin
                    o_job_pop = 1'b1;
                    if (i_job.cls == arpr_pkg::CLS_ARP_US) begin
                        w_rd_en   = 1'b1;
                        w_rd_bank = i_job.bank;
                        w_rd_k    = '0;
                        n_bank    = i_job.bank;
                        n_k       = '0;
                        n_state   = arpr_pkg::B_RUN;
                    end else begin
                        n_tx_valid = 1'b1;
                        n_tx       = '{tx_byte: 8'h00, tx_valid: 1'b0,
                                       frame_class: i_job.cls, run_end: 1'b1};
                    end
                end
            end
            arpr_pkg::B_RUN: begin
                if (w_out_free) begin
                    n_tx_valid = 1'b1;
                    n_tx       = '{tx_byte: w_byte, tx_valid: 1'b1,
                                   frame_class: arpr_pkg::CLS_ARP_US,
                                   run_end: (r_k == RW'(arpr_pkg::REPLY_LEN - 1))};
                    if (r_k == RW'(arpr_pkg::REPLY_LEN - 1)) begin
                        o_status = '{done: 1'b1, bank: r_bank};
                        n_state  = arpr_pkg::B_IDLE;
                    end else begin
                        n_k     = r_k + RW'(1);
                        w_rd_en = 1'b1;
                        w_rd_k  = r_k + RW'(1);
                    end
                end
            end
            default: begin
                n_state = arpr_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= arpr_pkg::B_IDLE;
            r_tx_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tx_valid <= n_tx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_bank <= n_bank;
        r_tx   <= n_tx;
    end

    assign o_tx_valid = r_tx_valid;
    assign o_tx       = r_tx;

endmodule

### rtl/core/arp_responder_with_ping_detect.sv
// ----------------------------------------------------------------------------
// ARP responder with ping detection
// Answers ARP requests for the configured IPv4 address and flags pings.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle unless stalled. After a frame's last
// byte the receive side classifies it and resumes. Every frame yields one
// status transaction, except an ARP request for our address, which yields
// the 42 reply bytes at one per cycle unless the sink stalls, read from a
// two-bank header buffer (one read port). Reception goes on while a reply
// drains; it stalls to classify, and while the two-entry job queue is full
// or both header banks hold unsent replies. No clearing pass after reset.
module arp_responder_with_ping_detect #(
    parameter int HEADER_BYTES    = 42,
    parameter int MAX_FRAME_BYTES = 1520
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rx_valid,
    output logic                                o_rx_ready,
    input  arpr_pkg::t_rx_item                  i_rx,
    output logic                                o_tx_valid,
    input  logic                                i_tx_ready,
    output arpr_pkg::t_tx_item                  o_tx,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [arpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [47:0]                         i_cfg_data
);

    localparam int HW = $clog2(HEADER_BYTES);

    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;

    logic                   w_wr_en;
    logic                   w_wr_bank;
    logic [HW-1:0]          w_wr_idx;
    logic [7:0]             w_wr_data;
    logic                   w_push;
    arpr_pkg::t_job         w_job_in;
    logic                   w_fifo_full;
    logic                   w_job_valid;
    arpr_pkg::t_job         w_job_out;
    logic                   w_job_pop;
    arpr_pkg::t_back_status w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                arpr_pkg::CFG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                arpr_pkg::CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    arpr_front #(
        .HEADER_BYTES    (HEADER_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx        (i_rx),
        .i_own_ip    (r_own_ip),
        .o_wr_en     (w_wr_en),
        .o_wr_bank   (w_wr_bank),
        .o_wr_idx    (w_wr_idx),
        .o_wr_data   (w_wr_data),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .i_fifo_full (w_fifo_full),
        .i_status    (w_status)
    );

    arpr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_fifo_full),
        .o_valid (w_job_valid),
        .o_data  (w_job_out),
        .i_pop   (w_job_pop)
    );

    arpr_back #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_wr_en),
        .i_wr_bank   (w_wr_bank),
        .i_wr_idx    (w_wr_idx),
        .i_wr_data   (w_wr_data),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_own_mac   (r_own_mac),
        .o_status    (w_status),
        .o_tx_valid  (o_tx_valid),
        .i_tx_ready  (i_tx_ready),
        .o_tx        (o_tx)
    );

`include "arp_responder_with_ping_detect_assert.svh"

    `ARPR_ASSERT_IMPL(a_queue_no_overflow, i_clk, i_rst_n, w_push, !w_fifo_full)
    `ARPR_ASSERT_IMPL(a_reply_byte_class, i_clk, i_rst_n, o_tx_valid && o_tx.tx_valid, o_tx.frame_class == arpr_pkg::CLS_ARP_US)
    `ARPR_ASSERT_IMPL(a_status_ends_run, i_clk, i_rst_n, o_tx_valid && !o_tx.tx_valid, o_tx.run_end)
    `ARPR_ASSERT_NEXT(a_done_shows_last, i_clk, i_rst_n, w_status.done, o_tx_valid && o_tx.run_end)

endmodule
